>>> sv/code_table_symbol_encoder_unit_assert.svh
// assertion macros for the code table symbol encoder
`ifndef CODE_TABLE_SYMBOL_ENCODER_UNIT_ASSERT_SVH
`define CODE_TABLE_SYMBOL_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define CTSE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctse assertion failed");
// next-cycle implication
`define CTSE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctse assertion failed");
`else
`define CTSE_ASSERT_IMP(label, ante, cons)
`define CTSE_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> sv/ctse_pkg.sv
// shared types and constants of the code table symbol encoder
package ctse_pkg;

  // request command codes
  localparam logic [1:0] CMD_SET_LEN = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_ENCODE  = 2'd2;

  // widest code length over the whole parameter range (up to 64 digits)
  localparam int ENTRY_LEN_W = 7;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_ENCODE = 1'b1
  } kind_t;

  // one input request as it comes off the stream
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
    logic [4:0] digit_index;
    logic [7:0] digit_value;
    logic [3:0] digit_width;
    logic [5:0] code_length;
    logic       end_of_data;
  } ctse_in_t;

  // classified work for the back end
  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             symbol;
    logic [4:0]             digit_index;
    logic [7:0]             digit_value;
    logic [3:0]             digit_width;
    logic [ENTRY_LEN_W-1:0] code_length;
    logic                   end_of_data;
  } ctse_entry_t;

  // queue status seen by both ends
  typedef struct packed {
    logic valid;
    logic full;
  } ctse_qstat_t;

  // one result
  typedef struct packed {
    logic [7:0] out_value;
    logic [3:0] out_width;
    logic       last_digit;
    logic       stream_end;
  } ctse_out_t;

endpackage

>>> sv/ctse_front.sv
// front end: accepts requests, owns the length table, classifies work for the back end
module ctse_front import ctse_pkg::*; #(
  parameter int MAX_DEPTH = 32,
  parameter int SYMBOLS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctse_in_t    in_item,
  output logic        push,
  output ctse_entry_t push_entry,
  input  ctse_qstat_t q_stat
);

  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int LEN_W = $clog2(MAX_DEPTH + 1);

  logic [LEN_W-1:0] len_mem [SYMBOLS];
  logic [SYMBOLS-1:0] len_valid;

  logic             accept;
  logic             in_sym_ok;
  logic             in_len_sat;
  logic [LEN_W-1:0] in_len;
  logic             set_wr;
  logic [SYM_W-1:0] in_sym_idx;

  logic             stage_valid;
  ctse_in_t         stage;
  logic [LEN_W-1:0] rd_len;
  logic             rd_valid;

  logic             stage_sym_ok;
  logic             stage_idx_ok;
  logic [LEN_W-1:0] stage_len;
  logic             want;

  assign accept     = in_valid && in_ready;
  assign in_sym_idx = in_item.symbol[SYM_W-1:0];
  assign in_sym_ok  = {1'b0, in_item.symbol} < 9'(SYMBOLS);
  assign in_len_sat = 7'(in_item.code_length) > 7'(MAX_DEPTH);
  assign in_len     = in_len_sat ? LEN_W'(MAX_DEPTH) : LEN_W'(in_item.code_length);
  assign set_wr     = accept && (in_item.command == CMD_SET_LEN) && in_sym_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      len_valid   <= '0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (set_wr) begin
        len_valid[in_sym_idx] <= 1'b1;
      end
    end
  end

  // length table and its registered read, taken at the accept edge
  always_ff @(posedge clk) begin
    if (accept) begin
      stage    <= in_item;
      rd_len   <= len_mem[in_sym_idx];
      rd_valid <= len_valid[in_sym_idx];
    end
    if (set_wr) begin
      len_mem[in_sym_idx] <= in_len;
    end
  end

  assign stage_sym_ok = {1'b0, stage.symbol} < 9'(SYMBOLS);
  assign stage_idx_ok = 7'(stage.digit_index) < 7'(MAX_DEPTH);
  assign stage_len    = (stage_sym_ok && rd_valid) ? rd_len : '0;

  always_comb begin
    case (stage.command)
      CMD_WRITE:  want = stage_sym_ok && stage_idx_ok;
      CMD_ENCODE: want = (stage_len != '0) || stage.end_of_data;
      default:    want = 1'b0;
    endcase
  end

  always_comb begin
    push_entry.kind        = (stage.command == CMD_ENCODE) ? KIND_ENCODE : KIND_WRITE;
    push_entry.symbol      = stage.symbol;
    push_entry.digit_index = stage.digit_index;
    push_entry.digit_value = stage.digit_value;
    push_entry.digit_width = (stage.digit_width > 4'd8) ? 4'd8 : stage.digit_width;
    push_entry.code_length = ENTRY_LEN_W'(stage_len);
    push_entry.end_of_data = stage.end_of_data;
  end

  assign push     = stage_valid && want && !q_stat.full;
  assign in_ready = !stage_valid || !want || !q_stat.full;

endmodule

>>> sv/ctse_queue.sv
// short queue of classified work between front and back end
module ctse_queue import ctse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ctse_entry_t push_entry,
  input  logic        pop,
  output ctse_entry_t head,
  output ctse_qstat_t q_stat
);

  ctse_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (!push && pop) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.valid = count != '0;
  assign q_stat.full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);

endmodule

>>> sv/ctse_back.sv
// back end: digit memory, digit writes and the per-digit encode sequencer
module ctse_back import ctse_pkg::*; #(
  parameter int MAX_DEPTH = 32,
  parameter int SYMBOLS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  ctse_qstat_t q_stat,
  input  ctse_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output ctse_out_t   out_item
);

  localparam int SYM_W     = $clog2(SYMBOLS);
  localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DEPTH_ALL = SYMBOLS * MAX_DEPTH;
  localparam int ADDR_W    = $clog2(DEPTH_ALL);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  logic [11:0] digit_mem [DEPTH_ALL];
  logic [11:0] rd_data;

  state_t           state;
  logic [SYM_W-1:0] cur_sym;
  logic [LEN_W-1:0] cur_len;
  logic             cur_eod;
  logic [IDX_W-1:0] cnt;
  logic             out_zero;
  logic             last_flag;
  logic             stream_flag;

  logic              out_free;
  logic              issue;
  logic              rd_en;
  logic              wr_en;
  logic              cnt_last;
  logic              done;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign out_free = !out_valid || out_ready;
  assign issue    = (state == ST_RUN) && out_free;
  assign rd_en    = issue && (cur_len != '0);
  assign cnt_last = (8'(cnt) + 8'd1) == 8'(cur_len);
  assign done     = (cur_len == '0) || cnt_last;
  assign pop      = (state == ST_IDLE) && q_stat.valid;
  assign wr_en    = pop && (head.kind == KIND_WRITE);

  assign wr_addr = ADDR_W'(head.symbol[SYM_W-1:0]) * ADDR_W'(MAX_DEPTH)
                 + ADDR_W'(head.digit_index);
  assign rd_addr = ADDR_W'(cur_sym) * ADDR_W'(MAX_DEPTH) + ADDR_W'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_stat.valid && (head.kind == KIND_ENCODE)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue && done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_sym <= head.symbol[SYM_W-1:0];
      cur_len <= LEN_W'(head.code_length);
      cur_eod <= head.end_of_data;
      cnt     <= '0;
    end
    if (issue) begin
      cnt         <= cnt + IDX_W'(1);
      out_zero    <= cur_len == '0;
      last_flag   <= done;
      stream_flag <= done && cur_eod;
    end
  end

  // digit memory: one write or one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[wr_addr] <= {head.digit_width, head.digit_value};
    end
    if (rd_en) begin
      rd_data <= digit_mem[rd_addr];
    end
  end

  assign out_item.out_value  = out_zero ? 8'd0 : rd_data[7:0];
  assign out_item.out_width  = out_zero ? 4'd0 : rd_data[11:8];
  assign out_item.last_digit = last_flag;
  assign out_item.stream_end = stream_flag;

endmodule

>>> sv/code_table_symbol_encoder_unit.sv
// top level of the code table symbol encoder
// Prefix-code encoder driven by one request stream: a set request loads a
// symbol's code length, a write request stores one digit (value and bit
// width) of a symbol's code, and an encode request emits the symbol's
// digits one result per cycle while the output is not stalled, the last
// one flagged on tlast and, for the final byte of the stream, on tuser.
// An unmapped final byte still gives one zero-width result. The front
// end takes a request every cycle while the four-entry work queue has
// room; set requests finish there against the length table. In the back
// end a digit write is done from the idle state, and an encode first
// loads the job and then reads one digit per cycle, while the output is
// not stalled, from the single-ported digit memory. Output stalls hold
// the digit sequencer; the length table reads zero lengths right after
// reset, digits read back undefined until written.
`include "code_table_symbol_encoder_unit_assert.svh"

module code_table_symbol_encoder_unit import ctse_pkg::*; #(
  parameter int MAX_DEPTH = 32,
  parameter int SYMBOLS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // symbol[7:0], digit_index[12:8], digit_value[20:13], digit_width[24:21],
  // code_length[30:25], zero[31]
  input  logic [31:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  // end_of_data
  input  logic        s_tlast,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_value[7:0], out_width[11:8], zero[15:12]
  output logic [15:0] m_tdata,
  // stream_end[0]
  output logic [0:0]  m_tuser,
  // last_digit
  output logic        m_tlast
);

  ctse_in_t    in_item;
  ctse_entry_t push_entry;
  ctse_entry_t head;
  ctse_qstat_t q_stat;
  ctse_out_t   out_item;
  logic        push;
  logic        pop;

  // unpack the request
  assign in_item.command     = s_tuser;
  assign in_item.symbol      = s_tdata[7:0];
  assign in_item.digit_index = s_tdata[12:8];
  assign in_item.digit_value = s_tdata[20:13];
  assign in_item.digit_width = s_tdata[24:21];
  assign in_item.code_length = s_tdata[30:25];
  assign in_item.end_of_data = s_tlast;

  // front end: length table lookup and classification
  ctse_front #(
    .MAX_DEPTH (MAX_DEPTH),
    .SYMBOLS   (SYMBOLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .push       (push),
    .push_entry (push_entry),
    .q_stat     (q_stat)
  );

  // work queue decoupling the two ends
  ctse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back end: digit memory and encode sequencer
  ctse_back #(
    .MAX_DEPTH (MAX_DEPTH),
    .SYMBOLS   (SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // pack the result
  assign m_tdata = {4'b0000, out_item.out_width, out_item.out_value};
  assign m_tuser = out_item.stream_end;
  assign m_tlast = out_item.last_digit;

  // the front end never pushes into a full queue
  `CTSE_ASSERT_IMP(a_no_push_full, push, !q_stat.full)
  // the back end only pops real work
  `CTSE_ASSERT_IMP(a_no_pop_empty, pop, q_stat.valid)
  // end of stream is only flagged on the last digit of a byte
  `CTSE_ASSERT_IMP(a_end_on_last, m_tvalid && m_tuser[0], m_tlast)

endmodule
